>>> src/svsg_pkg.sv
`default_nettype none

package svsg_pkg;

  typedef logic [7:0] seg_t;
  typedef logic [3:0] bcd_t;
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_RIGHT = 2'd0;
  localparam mode_t MODE_LEFT  = 2'd1;
  localparam mode_t MODE_GAP   = 2'd2;

  localparam seg_t SEG_MINUS = 8'h40;
  localparam seg_t SEG_BLANK = 8'h00;

  localparam int VALUE_W     = 16;
  localparam int MAG_W       = 14;
  localparam int ALIGNED_MAX = 9999;
  localparam int ALIGNED_MIN = -999;
  localparam int GAP_MIN     = 100;
  localparam int GAP_MAX     = 999;

  typedef struct packed {
    bcd_t [3:0] dig;
    logic [2:0] ndig;
    logic       neg;
    logic       aligned_ok;
    logic       gap_ok;
  } digits_t;

  function automatic seg_t seg_of(input bcd_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/signed_value_to_seven_segment_unit.sv
// a transaction passes the input register and then the result register before result valid
// throughput: one transaction per cycle, sustained when out_stall is low
// the input register feeds one pass of digit split and formatting into the result register
// rst_n is synchronous and active low; it clears both valid flags, payload is not reset
`default_nettype none

module signed_value_to_seven_segment_unit
  import svsg_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire mode_t                     in_mode,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output seg_t                           out_segments_pos0,
  output seg_t                           out_segments_pos1,
  output seg_t                           out_segments_pos2,
  output seg_t                           out_segments_pos3,
  output logic                           out_out_of_range
);

  logic                      s1_valid_r;
  logic signed [VALUE_W-1:0] s1_value_r;
  mode_t                     s1_mode_r;
  logic                      out_valid_r;
  seg_t [3:0]                out_pos_r;
  logic                      out_flag_r;

  logic       out_free;
  logic       s1_free;
  digits_t    digits;
  seg_t [3:0] pos_nxt;
  logic       flag_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = !s1_free;

  svsg_digits u_digits (
    .value  (s1_value_r),
    .digits (digits)
  );

  svsg_format u_format (
    .mode         (s1_mode_r),
    .digits       (digits),
    .pos          (pos_nxt),
    .out_of_range (flag_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_value_r <= in_value;
      s1_mode_r  <= in_mode;
    end
    if (out_free && s1_valid_r) begin
      out_pos_r  <= pos_nxt;
      out_flag_r <= flag_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segments_pos0 = out_pos_r[0];
  assign out_segments_pos1 = out_pos_r[1];
  assign out_segments_pos2 = out_pos_r[2];
  assign out_segments_pos3 = out_pos_r[3];
  assign out_out_of_range  = out_flag_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a held result");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_free) |=> out_valid_r)
    else $error("stage one transaction lost");

  a_flag_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flag_r) |->
      ((out_pos_r[0] == out_pos_r[1]) && (out_pos_r[1] == out_pos_r[2]) &&
       (out_pos_r[2] == out_pos_r[3]) &&
       ((out_pos_r[0] == SEG_MINUS) || (out_pos_r[0] == SEG_BLANK))))
    else $error("out of range result not uniform");

  a_no_dp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      !(out_pos_r[0][7] || out_pos_r[1][7] || out_pos_r[2][7] || out_pos_r[3][7]))
    else $error("decimal point set");

endmodule

`default_nettype wire

>>> src/svsg_digits.sv
`default_nettype none

module svsg_digits
  import svsg_pkg::*;
(
  input  wire logic signed [VALUE_W-1:0] value,
  output digits_t                        digits
);

  logic signed [VALUE_W-1:0] neg_value;
  logic [MAG_W-1:0] mag;
  logic [26:0] prod1, prod2, prod3;
  logic [MAG_W-1:0] q1, q2, q3;
  logic [MAG_W-1:0] r0, r1, r2;

  always_comb begin
    neg_value = -value;
    digits.neg = value[VALUE_W-1];
    digits.aligned_ok = (value >= 16'(ALIGNED_MIN)) && (value <= 16'(ALIGNED_MAX));
    digits.gap_ok = (value >= 16'(GAP_MIN)) && (value <= 16'(GAP_MAX));
    mag = digits.neg ? neg_value[MAG_W-1:0] : value[MAG_W-1:0];

    // reciprocal multiplies, exact for magnitudes below ten thousand
    prod1 = 27'(mag) * 27'd6554;
    prod2 = 27'(mag) * 27'd5243;
    prod3 = 27'(mag) * 27'd8389;
    q1 = MAG_W'(prod1[25:16]);
    q2 = MAG_W'(prod2[25:19]);
    q3 = MAG_W'(prod3[26:23]);

    r0 = mag - MAG_W'(q1 * MAG_W'(10));
    r1 = q1 - MAG_W'(q2 * MAG_W'(10));
    r2 = q2 - MAG_W'(q3 * MAG_W'(10));
    digits.dig[0] = r0[3:0];
    digits.dig[1] = r1[3:0];
    digits.dig[2] = r2[3:0];
    digits.dig[3] = q3[3:0];

    if (mag >= MAG_W'(1000)) begin
      digits.ndig = 3'd4;
    end else if (mag >= MAG_W'(100)) begin
      digits.ndig = 3'd3;
    end else if (mag >= MAG_W'(10)) begin
      digits.ndig = 3'd2;
    end else begin
      digits.ndig = 3'd1;
    end
  end

endmodule

`default_nettype wire

>>> src/svsg_format.sv
`default_nettype none

module svsg_format
  import svsg_pkg::*;
(
  input  wire mode_t   mode,
  input  wire digits_t digits,
  output seg_t [3:0]   pos,
  output logic         out_of_range
);

  logic [2:0] pp;
  logic [2:0] j;
  logic [2:0] off;

  always_comb begin
    pos = {4{SEG_BLANK}};
    out_of_range = 1'b0;
    pp = 3'd0;
    j = 3'd0;
    off = {2'b00, digits.neg};
    if (mode == MODE_GAP) begin
      if (!digits.gap_ok) begin
        out_of_range = 1'b1;
      end else begin
        pos[0] = seg_of(digits.dig[2]);
        pos[1] = seg_of(digits.dig[1]);
        pos[2] = SEG_BLANK;
        pos[3] = seg_of(digits.dig[0]);
      end
    end else if (!digits.aligned_ok) begin
      pos = {4{SEG_MINUS}};
      out_of_range = 1'b1;
    end else if (mode == MODE_RIGHT) begin
      for (int p = 0; p < 4; p++) begin
        j = 3'(3 - p);
        if (j < digits.ndig) begin
          pos[p] = seg_of(digits.dig[j[1:0]]);
        end else if (digits.neg && (j == digits.ndig)) begin
          pos[p] = SEG_MINUS;
        end
      end
    end else begin
      // left aligned, mode code three lands here too
      for (int p = 0; p < 4; p++) begin
        pp = 3'(p);
        j = digits.ndig + off - 3'd1 - pp;
        if ((pp >= off) && (pp < digits.ndig + off)) begin
          pos[p] = seg_of(digits.dig[j[1:0]]);
        end else if (digits.neg && (pp == 3'd0)) begin
          pos[p] = SEG_MINUS;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/signed_value_to_seven_segment_unit_tb.sv
`default_nettype none

module signed_value_to_seven_segment_unit_tb
  import svsg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam logic [79:0] DIGIT_SEGS = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                        8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

  typedef struct packed {
    seg_t [3:0] seg;
    logic       oor;
  } display_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VALUE_W-1:0] in_value = '0;
  mode_t in_mode = MODE_RIGHT;
  logic out_valid;
  logic out_stall = 1'b0;
  seg_t out_segments_pos0;
  seg_t out_segments_pos1;
  seg_t out_segments_pos2;
  seg_t out_segments_pos3;
  logic out_out_of_range;

  display_t expected_displays[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;

  signed_value_to_seven_segment_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value          (in_value),
    .in_mode           (in_mode),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_segments_pos0 (out_segments_pos0),
    .out_segments_pos1 (out_segments_pos1),
    .out_segments_pos2 (out_segments_pos2),
    .out_segments_pos3 (out_segments_pos3),
    .out_out_of_range  (out_out_of_range)
  );

  always #2 clk = ~clk;

  function automatic seg_t digit_pattern(input int d);
    return DIGIT_SEGS[d*8 +: 8];
  endfunction

  function automatic display_t encode_display(input logic signed [VALUE_W-1:0] v,
                                              input mode_t m);
    display_t d;
    int val;
    int mag;
    int nd;
    int cnt;
    int first;
    int last;
    int t;
    logic neg;
    d = '0;
    val = v;
    if (m == MODE_GAP) begin
      if (val < GAP_MIN || val > GAP_MAX) begin
        d.oor = 1'b1;
      end else begin
        d.seg[3] = digit_pattern(val % 10);
        d.seg[1] = digit_pattern((val / 10) % 10);
        d.seg[0] = digit_pattern(val / 100);
        d.seg[2] = SEG_BLANK;
      end
    end else if (val > ALIGNED_MAX || val < ALIGNED_MIN) begin
      d.seg = {4{SEG_MINUS}};
      d.oor = 1'b1;
    end else begin
      neg = (val < 0);
      mag = neg ? -val : val;
      nd = 1;
      t = mag;
      while (t >= 10) begin
        t = t / 10;
        nd++;
      end
      cnt = nd + (neg ? 1 : 0);
      if (m == MODE_RIGHT) begin
        first = 4 - cnt;
        last = 3;
      end else begin
        first = 0;
        last = cnt - 1;
      end
      for (int k = 0; k < nd; k++) begin
        d.seg[last - k] = digit_pattern(mag % 10);
        mag = mag / 10;
      end
      if (neg) d.seg[first] = SEG_MINUS;
    end
    return d;
  endfunction

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_value(input int v, input mode_t m);
    int g;
    in_valid <= 1'b1;
    in_value <= v[VALUE_W-1:0];
    in_mode <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_displays.push_back(encode_display(v[VALUE_W-1:0], m));
    g = gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_value(0, MODE_RIGHT);
    send_value(-1, MODE_RIGHT);
    send_value(9, MODE_RIGHT);
    send_value(10, MODE_RIGHT);
    send_value(-99, MODE_RIGHT);
    send_value(-999, MODE_RIGHT);
    send_value(9999, MODE_RIGHT);
    send_value(10000, MODE_RIGHT);
    send_value(-1000, MODE_RIGHT);
    send_value(32767, MODE_RIGHT);
    send_value(-32768, MODE_LEFT);
    send_value(0, MODE_LEFT);
    send_value(-5, MODE_LEFT);
    send_value(1234, MODE_LEFT);
    send_value(-999, MODE_LEFT);
    send_value(9999, MODE_LEFT);
    send_value(100, MODE_GAP);
    send_value(999, MODE_GAP);
    send_value(99, MODE_GAP);
    send_value(1000, MODE_GAP);
    send_value(505, MODE_GAP);
    send_value(-500, MODE_GAP);
    send_value(-7, MODE_UNUSED);
    send_value(305, MODE_UNUSED);
    send_value(-32768, MODE_UNUSED);
  endtask

  task automatic test_aligned_random(input int n);
    int v;
    mode_t m;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom_range(0, 10998) - 999;
        1: v = $urandom_range(0, 198) - 99;
        2: v = $urandom_range(0, 20) - 10;
        default: v = $urandom_range(0, 11998) - 1999;
      endcase
      m = mode_t'($urandom_range(0, 3));
      if (m == MODE_GAP) m = MODE_RIGHT;
      send_value(v, m);
    end
  endtask

  task automatic test_gap_random(input int n);
    int v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 939) + 80;
      else v = $urandom_range(GAP_MIN, GAP_MAX);
      send_value(v, MODE_GAP);
    end
  endtask

  task automatic test_full_range(input int n);
    for (int i = 0; i < n; i++) begin
      send_value($urandom() & 32'hffff, mode_t'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_back_to_back(input int n);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    test_aligned_random(n / 2);
    test_gap_random(n / 2);
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        n = pick_gap();
        repeat (n < 1 ? 1 : n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    display_t exp_d;
    display_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.seg = {out_segments_pos3, out_segments_pos2, out_segments_pos1, out_segments_pos0};
      got.oor = out_out_of_range;
      if (expected_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transaction: seg %h oor %b", got.seg, got.oor);
      end else begin
        exp_d = expected_displays.pop_front();
        if (got.seg[0] !== exp_d.seg[0] || got.seg[1] !== exp_d.seg[1] ||
            got.seg[2] !== exp_d.seg[2] || got.seg[3] !== exp_d.seg[3] ||
            got.oor !== exp_d.oor) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: pos0..3 exp %h %h %h %h oor %b, got %h %h %h %h oor %b",
                     exp_d.seg[0], exp_d.seg[1], exp_d.seg[2], exp_d.seg[3], exp_d.oor,
                     got.seg[0], got.seg[1], got.seg[2], got.seg[3], got.oor);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_aligned_random(300);
    test_gap_random(180);
    test_full_range(150);
    test_back_to_back(100);
    in_valid <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_displays.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
